[hdl/ordered_key_value_table_top_assert.svh]
// assertion macros for the ordered key/value table
// expects clk and arst_n in the scope of use
`ifndef ORDERED_KEY_VALUE_TABLE_TOP_ASSERT_SVH
`define ORDERED_KEY_VALUE_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define KVT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/kvt_pkg.sv]
// types, codes and defaults shared by the ordered key/value table
// no dependencies
package kvt_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef enum logic [2:0] {
		ACT_SUBSCRIPT  = 3'd0,
		ACT_GET        = 3'd1,
		ACT_ASSIGN     = 3'd2,
		ACT_POP        = 3'd3,
		ACT_SETDEFAULT = 3'd4,
		ACT_CLEAR      = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic signed [63:0] key;
		logic [31:0]        value;
	} entry_t;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [63:0] key;
		logic [31:0]        value;
		logic               has_default;
		logic [31:0]        default_value;
	} req_t;

	typedef struct packed {
		logic [4:0]  entry_count;
		logic        found;
		logic [31:0] result_value;
		logic [1:0]  status;
	} result_t;

endpackage

[hdl/kvt_mem.sv]
// entry memory: one write port, one read port, registered read data
// depends on kvt_pkg
module kvt_mem #(
	parameter int DEPTH = kvt_pkg::CAPACITY_DEF,
	parameter int IW    = 4
) (
	input  logic            clk,
	input  logic            we,
	input  logic [IW-1:0]   waddr,
	input  kvt_pkg::entry_t wdata,
	input  logic            re,
	input  logic [IW-1:0]   raddr,
	output kvt_pkg::entry_t rdata
);
	import kvt_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/kvt_ctrl.sv]
// request sequencer: linear search, update, append and shift-down over the entry memory
// depends on kvt_pkg
module kvt_ctrl #(
	parameter int CAPACITY = kvt_pkg::CAPACITY_DEF,
	parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  kvt_pkg::req_t    req,
	input  logic [31:0]      none_value,
	output logic             res_valid,
	input  logic             res_ready,
	output kvt_pkg::result_t res,
	output logic             mem_we,
	output logic [IW-1:0]    mem_waddr,
	output kvt_pkg::entry_t  mem_wdata,
	output logic             mem_re,
	output logic [IW-1:0]    mem_raddr,
	input  kvt_pkg::entry_t  mem_rdata
);
	import kvt_pkg::*;

	state_t        state_q, state_d;
	req_t          req_q;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [IW-1:0] chk_q, chk_d;
	logic [1:0]    st_q, st_d;
	logic [31:0]   val_q, val_d;
	logic          fnd_q, fnd_d;

	logic [CW-1:0] chk_nxt;
	logic [CW:0]   sh_nxt;
	logic          more, sh_more, searching, hit, fin, full;
	logic [31:0]   dflt;

	assign chk_nxt   = CW'(chk_q) + CW'(1);
	assign more      = chk_nxt < cnt_q;
	assign sh_nxt    = (CW+1)'(chk_nxt) + (CW+1)'(1);
	assign sh_more   = sh_nxt < (CW+1)'(cnt_q);
	assign searching = (req_q.action == ACT_SUBSCRIPT) || (req_q.action == ACT_GET)
		|| (req_q.action == ACT_ASSIGN) || (req_q.action == ACT_POP)
		|| (req_q.action == ACT_SETDEFAULT);
	assign hit       = searching && (cnt_q != '0) && (mem_rdata.key == req_q.key);
	assign fin       = hit || !searching || (cnt_q == '0) || !more;
	assign full      = cnt_q == CW'(CAPACITY);
	assign dflt      = req_q.has_default ? req_q.default_value : none_value;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (fin) begin
					if (hit && more && (req_q.action == ACT_POP)) begin
						state_d = S_SHIFT;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SHIFT: begin
				if (!sh_more) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory accesses and result
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = chk_q;
		mem_wdata = '{key: req_q.key, value: req_q.value};
		mem_re    = 1'b0;
		mem_raddr = '0;
		cnt_d     = cnt_q;
		chk_d     = chk_q;
		st_d      = st_q;
		val_d     = val_q;
		fnd_d     = fnd_q;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					mem_re = 1'b1;
					chk_d  = '0;
				end
			end
			S_SEARCH: begin
				if (!fin) begin
					mem_re    = 1'b1;
					mem_raddr = chk_nxt[IW-1:0];
					chk_d     = chk_nxt[IW-1:0];
				end else begin
					st_d  = ST_OK;
					val_d = '0;
					fnd_d = hit;
					unique case (req_q.action)
						ACT_SUBSCRIPT: begin
							if (hit) begin
								val_d = mem_rdata.value;
							end else begin
								st_d = ST_MISSING;
							end
						end
						ACT_GET: begin
							val_d = hit ? mem_rdata.value : dflt;
						end
						ACT_ASSIGN: begin
							if (hit) begin
								mem_we = 1'b1;
								val_d  = req_q.value;
							end else if (!full) begin
								mem_we    = 1'b1;
								mem_waddr = cnt_q[IW-1:0];
								cnt_d     = cnt_q + CW'(1);
								val_d     = req_q.value;
							end else begin
								st_d = ST_FULL;
							end
						end
						ACT_POP: begin
							if (hit) begin
								val_d = mem_rdata.value;
								if (more) begin
									mem_re    = 1'b1;
									mem_raddr = chk_nxt[IW-1:0];
								end else begin
									cnt_d = cnt_q - CW'(1);
								end
							end else if (req_q.has_default) begin
								val_d = req_q.default_value;
							end else begin
								st_d = ST_MISSING;
							end
						end
						ACT_SETDEFAULT: begin
							if (hit) begin
								val_d = mem_rdata.value;
							end else if (!full) begin
								mem_we    = 1'b1;
								mem_waddr = cnt_q[IW-1:0];
								mem_wdata = '{key: req_q.key, value: dflt};
								cnt_d     = cnt_q + CW'(1);
								val_d     = dflt;
							end else begin
								st_d = ST_FULL;
							end
						end
						ACT_CLEAR: begin
							cnt_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_SHIFT: begin
				// move the entry above the hole down by one
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
				if (sh_more) begin
					mem_re    = 1'b1;
					mem_raddr = sh_nxt[IW-1:0];
					chk_d     = chk_nxt[IW-1:0];
				end else begin
					cnt_d = cnt_q - CW'(1);
				end
			end
			S_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res = '{entry_count: 5'(cnt_q), found: fnd_q, result_value: val_q, status: st_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		chk_q <= chk_d;
		st_q  <= st_d;
		val_q <= val_d;
		fnd_q <= fnd_d;
	end

endmodule

[hdl/ordered_key_value_table_top.sv]
// top level of the ordered key/value table: stream ports, none_value register, output register
// depends on kvt_pkg, kvt_ctrl, kvt_mem and ordered_key_value_table_top_assert.svh
//
// channel   direction  handshake                 contents
// s_*       in         s_tvalid / s_tready       one request
// m_*       out        m_tvalid / m_tready       one result per request
// cfg_*     in         cfg_valid / cfg_ready     none_value write
//
// a request is accepted in idle, then search compares the entries one at a time, in order and
// at least once, as set by the single read port; a pop that hits then moves each later entry
// down in shift; done holds the result until the output register takes it
// reset clears the entry count and none_value; the memory is not cleared
// a result waits in the output register while the next request is taken
module ordered_key_value_table_top #(
	parameter int CAPACITY = kvt_pkg::CAPACITY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// action[2:0], key[66:3], value[98:67], has_default[99], default_value[131:100], zero fill
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0], result_value[33:2], found[34], entry_count[39:35]
	output logic [39:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);
	import kvt_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	req_t          req;
	result_t       res, out_q;
	logic          res_valid, res_ready, out_vld_q;
	logic [31:0]   none_q;
	logic          mem_we, mem_re;
	logic [IW-1:0] mem_waddr, mem_raddr;
	entry_t        mem_wdata, mem_rdata;

	assign req = '{
		action:        s_tdata[2:0],
		key:           s_tdata[66:3],
		value:         s_tdata[98:67],
		has_default:   s_tdata[99],
		default_value: s_tdata[131:100]
	};

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			none_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			none_q <= cfg_data;
		end
	end

	kvt_ctrl #(
		.CAPACITY(CAPACITY),
		.IW      (IW),
		.CW      (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.none_value(none_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	kvt_mem #(
		.DEPTH(CAPACITY),
		.IW   (IW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output register
	assign res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_q.entry_count, out_q.found, out_q.result_value, out_q.status};

`include "ordered_key_value_table_top_assert.svh"

	`KVT_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while busy")
	`KVT_ASSERT_NOW(a_busy_on_result, res_valid, !s_tready, "request port open with result pending")
	`KVT_ASSERT_NEXT(a_result_lands, res_valid && res_ready, m_tvalid, "result lost before output")

endmodule

[tb/ordered_key_value_table_top_tb.sv]
// self-checking testbench for the ordered key/value table top level
// a directed table of requests, then random phases under bursty input and stalled output
// depends on kvt_pkg and ordered_key_value_table_top
`timescale 1ns / 100ps

module ordered_key_value_table_top_tb;

	import kvt_pkg::*;

	localparam int          TABLE_DEPTH      = CAPACITY_DEF;
	localparam int          CLK_PERIOD       = 8;
	localparam int          RESET_CYCLES     = 11;
	localparam int          NUM_PHASES       = 7;
	localparam int          RANDOM_PER_PHASE = 100;
	localparam int          LONG_HOLD        = 400;
	localparam int          DRAIN_CYCLES     = 2 * TABLE_DEPTH + 8;
	localparam int unsigned TIMEOUT_CYCLES   = 600_000;
	localparam int          NUM_DIRECTED     = 22;

	localparam logic [2:0]  ACT_RSVD6 = 3'd6;
	localparam logic [2:0]  ACT_RSVD7 = 3'd7;
	localparam logic [63:0] KEY_MIN   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] KEY_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] KEY_NEG1  = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [2:0]  action;
		logic [63:0] key;
		logic [31:0] value;
		logic        has_default;
		logic [31:0] default_value;
		bit          typed;
		logic [1:0]  status;
		logic [31:0] result_value;
		logic        found;
		logic [4:0]  entry_count;
	} dir_row_t;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [135:0] s_tdata   = '0;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [39:0]  m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [31:0]  cfg_data  = '0;

	// model table
	logic [63:0] tbl_keys [TABLE_DEPTH];
	logic [31:0] tbl_vals [TABLE_DEPTH];
	int          tbl_count = 0;
	logic [31:0] none_reg  = '0;

	result_t pending_results [$];

	int errors          = 0;
	int results_checked = 0;
	int requests_sent   = 0;
	int cfg_writes      = 0;
	int full_rejects    = 0;
	int missing_errors  = 0;
	int pop_hits        = 0;
	int burst_left      = 1;
	bit no_gaps         = 1'b0;
	int hold_asked      = 0;
	int hold_served     = 0;

	// action, key, value, has_default, default_value, typed, status, result_value, found, count
	dir_row_t directed_rows [NUM_DIRECTED] = '{
		'{ACT_SUBSCRIPT,  64'd0,    32'h0,         1'b0, 32'h0,         1'b1, ST_MISSING,
			32'h0,         1'b0, 5'd0},
		'{ACT_GET,        KEY_MAX,  32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, ST_OK,
			32'h0,         1'b0, 5'd0},
		'{ACT_GET,        KEY_MIN,  32'h0,         1'b1, 32'hFFFF_FFFF, 1'b1, ST_OK,
			32'hFFFF_FFFF, 1'b0, 5'd0},
		'{ACT_POP,        64'd5,    32'h0,         1'b0, 32'h0,         1'b1, ST_MISSING,
			32'h0,         1'b0, 5'd0},
		'{ACT_POP,        64'd5,    32'h0,         1'b1, 32'h1234_5678, 1'b1, ST_OK,
			32'h1234_5678, 1'b0, 5'd0},
		'{ACT_ASSIGN,     KEY_MIN,  32'hFFFF_FFFF, 1'b0, 32'h0,         1'b1, ST_OK,
			32'hFFFF_FFFF, 1'b0, 5'd1},
		'{ACT_ASSIGN,     KEY_MAX,  32'h0,         1'b1, 32'hFFFF_FFFF, 1'b1, ST_OK,
			32'h0,         1'b0, 5'd2},
		'{ACT_ASSIGN,     KEY_NEG1, 32'hA5A5_A5A5, 1'b0, 32'h0,         1'b1, ST_OK,
			32'hA5A5_A5A5, 1'b0, 5'd3},
		'{ACT_SUBSCRIPT,  KEY_MIN,  32'h0,         1'b0, 32'h0,         1'b1, ST_OK,
			32'hFFFF_FFFF, 1'b1, 5'd3},
		'{ACT_ASSIGN,     KEY_MIN,  32'h1,         1'b0, 32'h0,         1'b1, ST_OK,
			32'h1,         1'b1, 5'd3},
		'{ACT_SETDEFAULT, 64'd0,    32'h0,         1'b0, 32'h5555_5555, 1'b1, ST_OK,
			32'h0,         1'b0, 5'd4},
		'{ACT_SETDEFAULT, 64'd5,    32'h0,         1'b1, 32'hDEAD_BEEF, 1'b1, ST_OK,
			32'hDEAD_BEEF, 1'b0, 5'd5},
		'{ACT_SETDEFAULT, 64'd5,    32'h0,         1'b1, 32'h7,         1'b1, ST_OK,
			32'hDEAD_BEEF, 1'b1, 5'd5},
		'{ACT_POP,        KEY_MAX,  32'h0,         1'b0, 32'h0,         1'b1, ST_OK,
			32'h0,         1'b1, 5'd4},
		'{ACT_SUBSCRIPT,  KEY_NEG1, 32'h0,         1'b0, 32'h0,         1'b0, ST_OK,
			32'h0,         1'b0, 5'd0},
		'{ACT_GET,        64'd5,    32'h0,         1'b1, 32'h0,         1'b0, ST_OK,
			32'h0,         1'b0, 5'd0},
		'{ACT_POP,        KEY_MIN,  32'h0,         1'b0, 32'h0,         1'b0, ST_OK,
			32'h0,         1'b0, 5'd0},
		'{ACT_POP,        64'd5,    32'h0,         1'b1, 32'hFFFF_FFFF, 1'b0, ST_OK,
			32'h0,         1'b0, 5'd0},
		'{ACT_RSVD6,      64'd5,    32'h0,         1'b0, 32'h0,         1'b1, ST_OK,
			32'h0,         1'b0, 5'd2},
		'{ACT_RSVD7,      KEY_NEG1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_OK,
			32'h0,         1'b0, 5'd2},
		'{ACT_CLEAR,      KEY_MAX,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_OK,
			32'h0,         1'b0, 5'd0},
		'{ACT_SUBSCRIPT,  KEY_NEG1, 32'h0,         1'b0, 32'h0,         1'b1, ST_MISSING,
			32'h0,         1'b0, 5'd0}
	};

	ordered_key_value_table_top #(
		.CAPACITY(TABLE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic result_t apply_request(input req_t rq);
		result_t     r;
		logic        hit;
		int          at;
		logic [31:0] fill;
		r   = '0;
		hit = 1'b0;
		at  = 0;
		r.status = ST_OK;
		if (rq.action <= ACT_SETDEFAULT) begin
			for (int i = 0; i < tbl_count; i++) begin
				if (!hit && tbl_keys[i] == rq.key) begin
					hit = 1'b1;
					at  = i;
				end
			end
		end
		case (rq.action)
			ACT_SUBSCRIPT: begin
				if (hit) r.result_value = tbl_vals[at];
				else r.status = ST_MISSING;
			end
			ACT_GET: begin
				if (hit) r.result_value = tbl_vals[at];
				else r.result_value = rq.has_default ? rq.default_value : none_reg;
			end
			ACT_ASSIGN: begin
				if (hit) begin
					tbl_vals[at]   = rq.value;
					r.result_value = rq.value;
				end else if (tbl_count < TABLE_DEPTH) begin
					tbl_keys[tbl_count] = rq.key;
					tbl_vals[tbl_count] = rq.value;
					tbl_count++;
					r.result_value = rq.value;
				end else begin
					r.status = ST_FULL;
				end
			end
			ACT_POP: begin
				if (hit) begin
					r.result_value = tbl_vals[at];
					for (int i = at; i + 1 < tbl_count; i++) begin
						tbl_keys[i] = tbl_keys[i + 1];
						tbl_vals[i] = tbl_vals[i + 1];
					end
					tbl_count--;
					pop_hits++;
				end else if (rq.has_default) begin
					r.result_value = rq.default_value;
				end else begin
					r.status = ST_MISSING;
				end
			end
			ACT_SETDEFAULT: begin
				fill = rq.has_default ? rq.default_value : none_reg;
				if (hit) begin
					r.result_value = tbl_vals[at];
				end else if (tbl_count < TABLE_DEPTH) begin
					tbl_keys[tbl_count] = rq.key;
					tbl_vals[tbl_count] = fill;
					tbl_count++;
					r.result_value = fill;
				end else begin
					r.status = ST_FULL;
				end
			end
			ACT_CLEAR: tbl_count = 0;
			default: ;
		endcase
		if (r.status == ST_FULL) full_rejects++;
		if (r.status == ST_MISSING) missing_errors++;
		r.found       = hit;
		r.entry_count = 5'(tbl_count);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic write_none_value(input logic [31:0] v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		none_reg = v;
		cfg_writes++;
	endtask

	// offer one request, record its expected result, then pace the burst
	task automatic issue(input req_t rq, input bit typed, input result_t typed_want);
		result_t predicted;
		int      gap;
		s_tdata  <= {4'b0, rq.default_value, rq.has_default, rq.value, rq.key, rq.action};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predicted = apply_request(rq);
		pending_results.push_back(typed ? typed_want : predicted);
		requests_sent++;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			gap = no_gaps ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request waiting", 64'(got), 64'd0);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got.status !== want.status)
					report_mismatch("status", 64'(got.status), 64'(want.status));
				if (got.result_value !== want.result_value)
					report_mismatch("result_value", 64'(got.result_value),
						64'(want.result_value));
				if (got.found !== want.found)
					report_mismatch("found", 64'(got.found), 64'(want.found));
				if (got.entry_count !== want.entry_count)
					report_mismatch("entry_count", 64'(got.entry_count),
						64'(want.entry_count));
			end
		end
	end

	initial begin : output_stalls
		int unsigned cyc;
		int          mode;
		cyc  = 0;
		mode = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_asked != hold_served) begin
				hold_served++;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (cyc % 96 == 0) mode = $urandom_range(0, 3);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ((cyc % 5) < 2);
				endcase
			end
		end
	end

	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		action_t     act_order [6];
		int          mix_edges [3][6];
		int          pool_sizes [NUM_PHASES];
		logic [63:0] key_pool [$];
		dir_row_t    row;
		req_t        rq;
		result_t     want;
		logic [31:0] setting;
		int          roll;
		int          act;
		int          mix;
		act_order  = '{ACT_SUBSCRIPT, ACT_GET, ACT_ASSIGN, ACT_POP, ACT_SETDEFAULT, ACT_CLEAR};
		// mixed, fill-heavy, drain-heavy
		mix_edges  = '{'{15, 30, 55, 75, 93, 96}, '{8, 16, 56, 66, 95, 97},
			'{15, 25, 40, 85, 95, 97}};
		pool_sizes = '{6, 40, 24, 30, 12, 48, 20};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// none_value still at its reset value here
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			rq.action        = row.action;
			rq.key           = row.key;
			rq.value         = row.value;
			rq.has_default   = row.has_default;
			rq.default_value = row.default_value;
			want.status       = row.status;
			want.result_value = row.result_value;
			want.found        = row.found;
			want.entry_count  = row.entry_count;
			issue(rq, row.typed, want);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: setting = 32'hFFFF_FFFF;
				1: setting = 32'h0;
				3: setting = 32'h8000_0001;
				5: setting = 32'h0000_0001;
				default: setting = $urandom;
			endcase
			write_none_value(setting);
			no_gaps = (ph == 2 || ph == 4 || ph == 5);
			// long output stall while requests keep coming
			if (ph == 2 || ph == 5) hold_asked++;
			key_pool.delete();
			for (int i = 0; i < pool_sizes[ph]; i++) key_pool.push_back({$urandom, $urandom});
			if (ph % 2 == 1) begin
				key_pool[0] = KEY_MIN;
				key_pool[1] = KEY_MAX;
			end
			mix = ph % 3;
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				roll = $urandom_range(0, 99);
				act  = 0;
				while (act < 6 && roll >= mix_edges[mix][act]) act++;
				if (act == 6) rq.action = $urandom_range(0, 1) ? ACT_RSVD6 : ACT_RSVD7;
				else rq.action = act_order[act];
				if ($urandom_range(0, 9) != 0)
					rq.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
				else
					rq.key = {$urandom, $urandom};
				rq.value       = $urandom;
				rq.has_default = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 9))
					0: rq.default_value = 32'h0;
					1: rq.default_value = 32'hFFFF_FFFF;
					default: rq.default_value = $urandom;
				endcase
				want = '0;
				issue(rq, 1'b0, want);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests over %0d none_value settings, %0d results checked",
			requests_sent, cfg_writes + 1, results_checked);
		$display("table-full rejections %0d, missing-key errors %0d, pops that hit %0d",
			full_rejects, missing_errors, pop_hits);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[ordered_key_value_table_top.f]
+incdir+hdl
hdl/kvt_pkg.sv
hdl/kvt_mem.sv
hdl/kvt_ctrl.sv
hdl/ordered_key_value_table_top.sv
tb/ordered_key_value_table_top_tb.sv
